>>> rtl/core/i2cc_pkg.sv
// ----------------------------------------------------------------------------
// i2cc_pkg
// Types and constants shared by the three-bus i2c host controller core.
// ----------------------------------------------------------------------------
package i2cc_pkg;

  localparam int NUM_BUS = 3;

  // bus code that maps to no controller
  localparam logic [1:0] BUS_NONE = 2'd3;
  localparam logic [1:0] MCU_BUS  = 2'd1;

  // control byte bits
  localparam int CTL_EN    = 7;
  localparam int CTL_IRQ   = 6;
  localparam int CTL_READ  = 5;
  localparam int CTL_START = 1;
  localparam logic [6:0] CTL_ACK = 7'h10;

  // microcontroller device addresses
  localparam logic [7:0] MCU_DEV_WR = 8'h4A;
  localparam logic [7:0] MCU_DEV_RD = 8'h4B;
  localparam logic [7:0] MCU_DEV_MASK = 8'hFE;

  // microcontroller register map
  localparam logic [7:0] REG_VERSION  = 8'h00;
  localparam logic [7:0] REG_REVISION = 8'h01;
  localparam logic [7:0] REG_BATTERY  = 8'h0B;
  localparam logic [7:0] REG_STATUS   = 8'h0F;
  localparam logic [7:0] REG_FLAG0    = 8'h10;
  localparam logic [7:0] REG_FLAG1    = 8'h11;
  localparam logic [7:0] REG_FLAG2    = 8'h12;
  localparam logic [7:0] REG_FLAG3    = 8'h13;
  localparam logic [7:0] REG_MASK0    = 8'h18;
  localparam logic [7:0] REG_MASK1    = 8'h19;
  localparam logic [7:0] REG_MASK2    = 8'h1A;
  localparam logic [7:0] REG_MASK3    = 8'h1B;
  localparam logic [7:0] REG_LCD_PWR  = 8'h22;
  localparam logic [7:0] REG_NOINC_A  = 8'h29;
  localparam logic [7:0] REG_NOINC_B  = 8'h2D;
  localparam logic [7:0] REG_NOINC_C  = 8'h4F;
  localparam logic [7:0] REG_NOINC_D  = 8'h61;
  localparam logic [7:0] REG_NOINC_E  = 8'h7F;
  localparam logic [7:0] REG_SEC      = 8'h30;
  localparam logic [7:0] REG_MIN      = 8'h31;
  localparam logic [7:0] REG_HOUR     = 8'h32;
  localparam logic [7:0] REG_WDAY     = 8'h33;
  localparam logic [7:0] REG_DAY      = 8'h34;
  localparam logic [7:0] REG_MONTH    = 8'h35;
  localparam logic [7:0] REG_YEAR     = 8'h36;

  // fixed read values
  localparam logic [7:0] VAL_VERSION  = 8'h13;
  localparam logic [7:0] VAL_REVISION = 8'h41;
  localparam logic [7:0] VAL_BATTERY  = 8'h64;
  localparam logic [7:0] VAL_STATUS   = 8'h02;

  typedef struct packed {
    logic       command;
    logic [1:0] bus;
    logic [7:0] value;
    logic [5:0] clock_seconds;
    logic [5:0] clock_minutes;
    logic [4:0] clock_hours;
    logic [4:0] clock_day;
    logic [3:0] clock_month;
    logic [6:0] clock_year;
  } in_t;

  typedef struct packed {
    logic [7:0] bus_data;
    logic [6:0] bus_control;
    logic       bus_irq;
    logic       mcu_irq;
  } out_t;

  typedef struct packed {
    logic [NUM_BUS-1:0][7:0] data_regs;
    logic [NUM_BUS-1:0][6:0] control_regs;
    logic [1:0]              byte_count;
    logic [7:0]              device_address;
    logic [7:0]              register_address;
    logic                    auto_increment;
    logic [31:0]             irq_flags;
    logic [31:0]             irq_mask;
  } state_t;

endpackage

>>> rtl/core/i2cc_step.sv
// ----------------------------------------------------------------------------
// i2cc_step
// Next-state and result logic for one register write, including the
// microcontroller read and write maps.
// ----------------------------------------------------------------------------
module i2cc_step (
  input  i2cc_pkg::in_t    item,
  input  i2cc_pkg::state_t cur,
  output i2cc_pkg::state_t nxt,
  output i2cc_pkg::out_t   res
);

  logic [1:0]  b;
  logic [7:0]  rd_data;
  logic [31:0] rd_flags;
  logic [7:0]  wr_byte;
  logic [31:0] wr_mask;
  logic [31:0] wr_flags;
  logic        wr_fire;
  logic [31:0] lcd_bits;
  logic [1:0]  bc_inc;
  logic        birq;
  logic [7:0]  year_mod;
  logic [7:0]  new_reg;

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    begin
      // divide by ten via reciprocal, exact for values below 128
      prod = {8'b0, v} * 15'd205;
      tens = prod[14:11];
      ones = v - 7'({3'b0, tens} * 7'd10);
      return {tens, ones[3:0]};
    end
  endfunction

  assign b = item.bus;
  assign year_mod = (item.clock_year >= 7'd100) ? {1'b0, item.clock_year - 7'd100}
                                                 : {1'b0, item.clock_year};
  assign wr_byte = cur.data_regs[b];

  // read map
  always_comb begin
    rd_data  = '0;
    rd_flags = cur.irq_flags;
    case (cur.register_address)
      i2cc_pkg::REG_VERSION:  rd_data = i2cc_pkg::VAL_VERSION;
      i2cc_pkg::REG_REVISION: rd_data = i2cc_pkg::VAL_REVISION;
      i2cc_pkg::REG_BATTERY:  rd_data = i2cc_pkg::VAL_BATTERY;
      i2cc_pkg::REG_STATUS:   rd_data = i2cc_pkg::VAL_STATUS;
      i2cc_pkg::REG_FLAG0: begin
        rd_data = cur.irq_flags[7:0];
        rd_flags[7:0] = '0;
      end
      i2cc_pkg::REG_FLAG1: begin
        rd_data = cur.irq_flags[15:8];
        rd_flags[15:8] = '0;
      end
      i2cc_pkg::REG_FLAG2: begin
        rd_data = cur.irq_flags[23:16];
        rd_flags[23:16] = '0;
      end
      i2cc_pkg::REG_FLAG3: begin
        rd_data = cur.irq_flags[31:24];
        rd_flags[31:24] = '0;
      end
      i2cc_pkg::REG_MASK0: rd_data = cur.irq_mask[7:0];
      i2cc_pkg::REG_MASK1: rd_data = cur.irq_mask[15:8];
      i2cc_pkg::REG_MASK2: rd_data = cur.irq_mask[23:16];
      i2cc_pkg::REG_MASK3: rd_data = cur.irq_mask[31:24];
      i2cc_pkg::REG_SEC:   rd_data = to_bcd({1'b0, item.clock_seconds});
      i2cc_pkg::REG_MIN:   rd_data = to_bcd({1'b0, item.clock_minutes});
      i2cc_pkg::REG_HOUR:  rd_data = to_bcd({2'b0, item.clock_hours});
      i2cc_pkg::REG_WDAY:  rd_data = '0;
      i2cc_pkg::REG_DAY:   rd_data = to_bcd({2'b0, item.clock_day});
      i2cc_pkg::REG_MONTH: rd_data = to_bcd({3'b0, item.clock_month});
      i2cc_pkg::REG_YEAR:  rd_data = to_bcd(year_mod[6:0]);
      default:             rd_data = '0;
    endcase
  end

  // lcd power command flag bits
  always_comb begin
    lcd_bits = '0;
    if (wr_byte[0]) lcd_bits = lcd_bits | 32'h1500_0000;
    if (wr_byte[1]) lcd_bits[25] = 1'b1;
    if (wr_byte[2]) lcd_bits[26] = 1'b1;
    if (wr_byte[3]) lcd_bits[27] = 1'b1;
    if (wr_byte[4]) lcd_bits[28] = 1'b1;
    if (wr_byte[5]) lcd_bits[29] = 1'b1;
  end

  // write map; flags only grow, so the last raise decides the interrupt
  always_comb begin
    wr_mask  = cur.irq_mask;
    wr_flags = cur.irq_flags;
    wr_fire  = 1'b0;
    case (cur.register_address)
      i2cc_pkg::REG_MASK0: begin
        wr_mask[7:0] = wr_byte;
        wr_fire = |(cur.irq_flags & ~wr_mask);
      end
      i2cc_pkg::REG_MASK1: begin
        wr_mask[15:8] = wr_byte;
        wr_fire = |(cur.irq_flags & ~wr_mask);
      end
      i2cc_pkg::REG_MASK2: begin
        wr_mask[23:16] = wr_byte;
        wr_fire = |(cur.irq_flags & ~wr_mask);
      end
      i2cc_pkg::REG_MASK3: begin
        wr_mask[31:24] = wr_byte;
        wr_fire = |(cur.irq_flags & ~wr_mask);
      end
      i2cc_pkg::REG_LCD_PWR: begin
        wr_flags = cur.irq_flags | lcd_bits;
        wr_fire  = (|wr_byte[5:0]) && (|(wr_flags & ~cur.irq_mask));
      end
      default: begin
        wr_fire = 1'b0;
      end
    endcase
  end

  assign bc_inc  = (cur.byte_count == 2'd3) ? 2'd3 : cur.byte_count + 2'd1;
  assign new_reg = cur.register_address + {7'b0, cur.auto_increment};

  always_comb begin
    nxt  = cur;
    res  = '0;
    birq = 1'b0;
    if (b != i2cc_pkg::BUS_NONE) begin
      if (!item.command) begin
        nxt.data_regs[b] = item.value;
      end else begin
        nxt.control_regs[b] = item.value[6:0];
        if (item.value[i2cc_pkg::CTL_EN]) begin
          birq = item.value[i2cc_pkg::CTL_IRQ];
          if (item.value[i2cc_pkg::CTL_READ]) begin
            if (item.value[i2cc_pkg::CTL_START]) nxt.byte_count = '0;
            nxt.register_address = new_reg;
            if (b == i2cc_pkg::MCU_BUS && cur.device_address == i2cc_pkg::MCU_DEV_RD) begin
              nxt.data_regs[b] = rd_data;
              nxt.irq_flags    = rd_flags;
            end else begin
              nxt.data_regs[b] = '0;
            end
          end else begin
            nxt.control_regs[b] = item.value[6:0] | i2cc_pkg::CTL_ACK;
            // start resets the counter before this byte counts
            if (item.value[i2cc_pkg::CTL_START]) begin
              nxt.byte_count = 2'd1;
            end else begin
              nxt.byte_count = bc_inc;
            end
            case (nxt.byte_count)
              2'd1: nxt.device_address = wr_byte;
              2'd2: begin
                nxt.register_address = wr_byte;
                if (b == i2cc_pkg::MCU_BUS &&
                    (cur.device_address & i2cc_pkg::MCU_DEV_MASK) == i2cc_pkg::MCU_DEV_WR) begin
                  nxt.auto_increment = !(wr_byte == i2cc_pkg::REG_NOINC_A ||
                                         wr_byte == i2cc_pkg::REG_NOINC_B ||
                                         wr_byte == i2cc_pkg::REG_NOINC_C ||
                                         wr_byte == i2cc_pkg::REG_NOINC_D ||
                                         wr_byte == i2cc_pkg::REG_NOINC_E);
                end
              end
              default: begin
                nxt.register_address = new_reg;
                if (b == i2cc_pkg::MCU_BUS && cur.device_address == i2cc_pkg::MCU_DEV_WR) begin
                  nxt.irq_mask  = wr_mask;
                  nxt.irq_flags = wr_flags;
                  res.mcu_irq   = wr_fire;
                end
              end
            endcase
          end
        end
      end
      res.bus_data    = nxt.data_regs[b];
      res.bus_control = nxt.control_regs[b];
      res.bus_irq     = birq;
    end
  end

endmodule

>>> rtl/core/i2c_controller_with_mcu_model_core.sv
// ----------------------------------------------------------------------------
// i2c_controller_with_mcu_model_core
// Three-bus i2c host controller with a modelled power-management mcu on bus 1.
// ----------------------------------------------------------------------------
// latency: an accepted item is taken by the input register, then stepped into
//   the result register once that register is free or being drained;
//   throughput: one item per cycle while out_ready is high, since the whole register write is decoded
//   by the step logic between the two registers.
// reset: synchronous rst_n clears both valid flags and all controller state.
module i2c_controller_with_mcu_model_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  i2cc_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cc_pkg::out_t   out_data
);

  i2cc_pkg::in_t    item_r;
  logic             item_valid_r;
  i2cc_pkg::out_t   res_r;
  logic             res_valid_r;
  i2cc_pkg::state_t state_r;
  i2cc_pkg::state_t state_nxt;
  i2cc_pkg::out_t   res_nxt;
  logic             advance;

  // step the item when the result register is free or being drained
  assign advance  = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  i2cc_step u_step (
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

endmodule

>>> tb/sv/i2cc_tb_pkg.sv
// ----------------------------------------------------------------------------
// i2cc_tb_pkg
// Register-write tracker for the three-bus i2c host controller: keeps its own
// copy of the bus and mcu state, works out the response to each accepted
// write and compares the block's responses with it in order.
// ----------------------------------------------------------------------------
package i2cc_tb_pkg;

  import i2cc_pkg::*;

  class host_write_tracker;

    bit [7:0]  data_r [NUM_BUS];
    bit [6:0]  ctrl_r [NUM_BUS];
    bit [1:0]  byte_cnt;
    bit [7:0]  dev_addr;
    bit [7:0]  reg_addr;
    bit        addr_step;
    bit [31:0] flags;
    bit [31:0] mask;

    out_t expected_results[$];
    int   mismatches;

    function new();
      foreach (data_r[k]) begin
        data_r[k] = '0;
        ctrl_r[k] = '0;
      end
      byte_cnt   = '0;
      dev_addr   = '0;
      reg_addr   = '0;
      addr_step  = 1'b0;
      flags      = '0;
      mask       = '0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function bit [7:0] to_bcd(bit [7:0] v);
      bit [7:0] tens;
      bit [7:0] ones;
      tens = v / 8'd10;
      ones = v % 8'd10;
      return {tens[3:0], ones[3:0]};
    endfunction

    function bit [7:0] read_mcu_reg(bit [7:0] r, in_t w);
      bit [4:0] sh;
      bit [7:0] v;
      sh = {r[1:0], 3'b000};
      case (r)
        REG_VERSION:  return VAL_VERSION;
        REG_REVISION: return VAL_REVISION;
        REG_BATTERY:  return VAL_BATTERY;
        REG_STATUS:   return VAL_STATUS;
        REG_FLAG0, REG_FLAG1, REG_FLAG2, REG_FLAG3: begin
          // reading a flag byte clears it
          v = flags[sh +: 8];
          flags[sh +: 8] = 8'h00;
          return v;
        end
        REG_MASK0, REG_MASK1, REG_MASK2, REG_MASK3: return mask[sh +: 8];
        REG_SEC:   return to_bcd({2'b0, w.clock_seconds});
        REG_MIN:   return to_bcd({2'b0, w.clock_minutes});
        REG_HOUR:  return to_bcd({3'b0, w.clock_hours});
        REG_WDAY:  return 8'h00;
        REG_DAY:   return to_bcd({3'b0, w.clock_day});
        REG_MONTH: return to_bcd({4'b0, w.clock_month});
        REG_YEAR:  return to_bcd({1'b0, w.clock_year} % 8'd100);
        default:   return 8'h00;
      endcase
    endfunction

    function bit write_mcu_reg(bit [7:0] r, bit [7:0] v);
      bit       fire;
      bit [4:0] sh;
      fire = 1'b0;
      sh = {r[1:0], 3'b000};
      if (r >= REG_MASK0 && r <= REG_MASK3) begin
        mask[sh +: 8] = v;
        fire = (flags & ~mask) != 0;
      end else if (r == REG_LCD_PWR) begin
        // bit 0 raises three flags at once, bits 1..5 one each
        for (int k = 0; k < 6; k++) begin
          if (v[k]) begin
            flags |= (k == 0) ? 32'h1500_0000 : (32'h1 << (24 + k));
            fire |= (flags & ~mask) != 0;
          end
        end
      end
      return fire;
    endfunction

    function void note_write(in_t w);
      out_t     r;
      bit [1:0] b;
      bit [7:0] v;
      bit [7:0] a;
      r = '0;
      b = w.bus;
      v = w.value;
      if (b != BUS_NONE) begin
        if (!w.command) begin
          data_r[b] = v;
        end else begin
          ctrl_r[b] = v[6:0];
          if (v[CTL_EN]) begin
            if (v[CTL_START]) byte_cnt = 2'd0;
            if (v[CTL_IRQ]) r.bus_irq = 1'b1;
            if (v[CTL_READ]) begin
              a = reg_addr;
              reg_addr = reg_addr + {7'b0, addr_step};
              if (b == MCU_BUS && dev_addr == MCU_DEV_RD) data_r[b] = read_mcu_reg(a, w);
              else data_r[b] = 8'h00;
            end else begin
              ctrl_r[b] |= CTL_ACK;
              if (byte_cnt != 2'd3) byte_cnt++;
              if (byte_cnt == 2'd1) begin
                dev_addr = data_r[b];
              end else if (byte_cnt == 2'd2) begin
                reg_addr = data_r[b];
                if (b == MCU_BUS && (dev_addr & MCU_DEV_MASK) == MCU_DEV_WR) begin
                  addr_step = !(reg_addr == REG_NOINC_A || reg_addr == REG_NOINC_B ||
                                reg_addr == REG_NOINC_C || reg_addr == REG_NOINC_D ||
                                reg_addr == REG_NOINC_E);
                end
              end else begin
                a = reg_addr;
                reg_addr = reg_addr + {7'b0, addr_step};
                if (b == MCU_BUS && dev_addr == MCU_DEV_WR) r.mcu_irq = write_mcu_reg(a, data_r[b]);
              end
            end
          end
        end
        r.bus_data    = data_r[b];
        r.bus_control = ctrl_r[b];
      end
      expected_results.push_back(r);
    endfunction

    task check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("response %h with no item pending", got));
      end else begin
        want = expected_results.pop_front();
        if (got.bus_data !== want.bus_data)
          report($sformatf("bus_data %h, want %h", got.bus_data, want.bus_data));
        if (got.bus_control !== want.bus_control)
          report($sformatf("bus_control %h, want %h", got.bus_control, want.bus_control));
        if (got.bus_irq !== want.bus_irq)
          report($sformatf("bus_irq %b, want %b", got.bus_irq, want.bus_irq));
        if (got.mcu_irq !== want.mcu_irq)
          report($sformatf("mcu_irq %b, want %b", got.mcu_irq, want.mcu_irq));
      end
    endtask

    task flush_leftovers();
      out_t lost;
      while (expected_results.size() != 0) begin
        lost = expected_results.pop_front();
        report($sformatf("no response for item, want %h", lost));
      end
    endtask

  endclass

endpackage

>>> tb/sv/i2c_controller_with_mcu_model_core_tb.sv
// ----------------------------------------------------------------------------
// i2c_controller_with_mcu_model_core_tb
// Drives register writes into the i2c host controller core: a few directed
// writes, then random address/data sessions with the mcu on bus 1 mixed with
// plain and malformed writes, random idles on both sides, every response
// checked against the tracker's prediction.
// ----------------------------------------------------------------------------
module i2c_controller_with_mcu_model_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import i2cc_pkg::*;
  import i2cc_tb_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  host_write_tracker tracker;
  int items_sent;
  bit sender_steady;

  i2c_controller_with_mcu_model_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic in_t make_item(bit cmd, bit [1:0] bus, bit [7:0] value);
    in_t w;
    w.command = cmd;
    w.bus     = bus;
    w.value   = value;
    if ($urandom_range(0, 4) == 0) begin
      // anything the field widths allow
      w.clock_seconds = 6'($urandom);
      w.clock_minutes = 6'($urandom);
      w.clock_hours   = 5'($urandom);
      w.clock_day     = 5'($urandom);
      w.clock_month   = 4'($urandom);
      w.clock_year    = 7'($urandom);
    end else begin
      w.clock_seconds = 6'($urandom_range(0, 59));
      w.clock_minutes = 6'($urandom_range(0, 59));
      w.clock_hours   = 5'($urandom_range(0, 23));
      w.clock_day     = 5'($urandom_range(1, 31));
      w.clock_month   = 4'($urandom_range(1, 12));
      w.clock_year    = 7'($urandom_range(0, 99));
    end
    return w;
  endfunction

  // enabled control byte; irq and the stored low bits vary
  function automatic bit [7:0] ctl_byte(bit start, bit rd);
    bit [7:0] c;
    c = 8'($urandom);
    c[CTL_EN]    = 1'b1;
    c[CTL_START] = start;
    c[CTL_READ]  = rd;
    if ($urandom_range(0, 3) != 0) c[CTL_IRQ] = 1'b0;
    return c;
  endfunction

  function automatic bit [7:0] pick_fixed_addr();
    case ($urandom_range(0, 4))
      0:       return REG_NOINC_A;
      1:       return REG_NOINC_B;
      2:       return REG_NOINC_C;
      3:       return REG_NOINC_D;
      default: return REG_NOINC_E;
    endcase
  endfunction

  function automatic bit [7:0] pick_read_reg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return REG_VERSION;
        1:       return REG_REVISION;
        2:       return REG_BATTERY;
        default: return REG_STATUS;
      endcase
    end
    if (r < 3) return REG_FLAG0 + 8'($urandom_range(0, 3));
    if (r == 3) return REG_MASK0 + 8'($urandom_range(0, 3));
    if (r < 7) return REG_SEC + 8'($urandom_range(0, 6));
    if (r == 7) return pick_fixed_addr();
    return 8'($urandom);
  endfunction

  function automatic bit [7:0] pick_write_reg();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return REG_MASK0 + 8'($urandom_range(0, 3));
    if (r < 7) return REG_LCD_PWR;
    if (r == 7) return pick_fixed_addr();
    return 8'($urandom);
  endfunction

  function automatic bit [7:0] pick_dev(bit [7:0] want);
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return want;
    if (r == 8) return want ^ 8'h01;
    return 8'($urandom);
  endfunction

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_item(input in_t w);
    int gap;
    gap = sender_steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    tracker.note_write(w);
    if (w.bus != BUS_NONE) items_sent++;
  endtask

  // device address then register address, each as data + enabled control
  task automatic mcu_select(bit [7:0] dev, bit [7:0] rg, bit [1:0] bus = MCU_BUS);
    push_item(make_item(1'b0, bus, dev));
    push_item(make_item(1'b1, bus, ctl_byte(1'b1, 1'b0)));
    push_item(make_item(1'b0, bus, rg));
    push_item(make_item(1'b1, bus, ctl_byte(1'b0, 1'b0)));
  endtask

  task automatic mcu_send(bit [7:0] v, bit [1:0] bus = MCU_BUS);
    push_item(make_item(1'b0, bus, v));
    push_item(make_item(1'b1, bus, ctl_byte(1'b0, 1'b0)));
  endtask

  task automatic mcu_fetch(bit [1:0] bus = MCU_BUS);
    push_item(make_item(1'b1, bus, ctl_byte(1'b0, 1'b1)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  initial begin
    int hold;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      hold = idle_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    in_t w;
    int  r;
    int  next_drain;
    bit [1:0] side_bus;

    tracker       = new();
    items_sent    = 0;
    sender_steady = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unmapped bus, plain buses, enable clear, read on a bus without devices
    push_item(make_item(1'b0, BUS_NONE, 8'hFF));
    push_item(make_item(1'b1, BUS_NONE, 8'hFF));
    push_item(make_item(1'b0, 2'd0, 8'h00));
    push_item(make_item(1'b0, 2'd2, 8'hFF));
    push_item(make_item(1'b1, 2'd2, 8'h7F));
    push_item(make_item(1'b1, 2'd0, 8'hE2));

    // lcd power with every bit set raises unmasked flags
    mcu_select(MCU_DEV_WR, REG_LCD_PWR);
    mcu_send(8'hFF);

    // flag byte read clears it, next address is unmapped
    mcu_select(MCU_DEV_RD, REG_FLAG3);
    mcu_fetch();
    mcu_fetch();

    // clock readback with all-ones then all-zeros inputs
    mcu_select(MCU_DEV_RD, REG_SEC);
    for (int f = 1; f >= 0; f--) begin
      w = make_item(1'b1, MCU_BUS, ctl_byte(1'b0, 1'b1));
      {w.clock_seconds, w.clock_minutes, w.clock_hours,
       w.clock_day, w.clock_month, w.clock_year} = f ? '1 : '0;
      push_item(w);
    end

    wait_drained();

    next_drain = items_sent + 120;
    while (items_sent < 500) begin
      if ($urandom_range(0, 14) == 0) sender_steady = !sender_steady;
      if (items_sent >= next_drain) begin
        wait_drained();
        next_drain += 120;
      end
      r = $urandom_range(0, 19);
      if (r < 7) begin
        mcu_select(pick_dev(MCU_DEV_WR), pick_write_reg());
        repeat ($urandom_range(1, 3)) mcu_send(pick_byte());
      end else if (r < 13) begin
        mcu_select(pick_dev(MCU_DEV_RD), pick_read_reg());
        repeat ($urandom_range(1, 8)) mcu_fetch();
      end else if (r < 15) begin
        // same session shape on a bus with no mcu
        side_bus = $urandom_range(0, 1) ? 2'd2 : 2'd0;
        mcu_select(pick_dev(MCU_DEV_WR), 8'($urandom), side_bus);
        mcu_send(8'($urandom), side_bus);
        mcu_fetch(side_bus);
      end else if (r < 17) begin
        // session cut off after the device byte, sometimes followed by control without enable
        push_item(make_item(1'b0, MCU_BUS, pick_dev(MCU_DEV_RD)));
        push_item(make_item(1'b1, MCU_BUS, ctl_byte(1'b1, 1'b0)));
        if ($urandom_range(0, 1))
          push_item(make_item(1'b1, MCU_BUS, 8'h7F & 8'($urandom)));
      end else begin
        push_item(make_item(1'($urandom), 2'($urandom_range(0, 3)), 8'($urandom)));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    tracker.flush_leftovers();
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> i2c_controller_with_mcu_model_core.f
rtl/core/i2cc_pkg.sv
rtl/core/i2cc_step.sv
rtl/core/i2c_controller_with_mcu_model_core.sv
tb/sv/i2cc_tb_pkg.sv
tb/sv/i2c_controller_with_mcu_model_core_tb.sv
